// ----- hdl/shape_overlap_test_top_defines.svh -----
// Assertion macros for the shape overlap test block.
`ifndef SHAPE_OVERLAP_TEST_TOP_DEFINES_SVH
`define SHAPE_OVERLAP_TEST_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SOT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SOT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sot_pkg.sv -----
// Shared types, codes and constants for the shape overlap test block.
package sot_pkg;

  localparam int COORD_W = 16;
  localparam int LEN_W   = 15;
  localparam int TYPE_W  = 2;

  // Shape kinds
  localparam logic [TYPE_W-1:0] TYPE_RECT   = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_CIRCLE = 2'd1;

  // Pairing of the two shapes in one request
  localparam logic [1:0] PAIR_NONE = 2'd0;
  localparam logic [1:0] PAIR_CC   = 2'd1;
  localparam int unsigned PAIR_RR_I = 2;
  localparam logic [1:0] PAIR_RR   = 2'(PAIR_RR_I);
  localparam logic [1:0] PAIR_CR   = 2'd3;

  // Cycles from request accept to result strobe
  localparam int LATENCY = 4;

endpackage

// ----- hdl/shape_overlap_test_top.sv -----
// Shape overlap test: pipelined circle / rectangle collision check.
//
// One request carries two shapes (type, x, y, width, height, radius each) and
// is accepted at a rising edge with start high and busy low. Each request gives
// exactly one result: hit is valid while done is high, for one cycle only.
// Throughput is one request per cycle while busy is low; the four
// register stages are edge differences and clamp terms, distance select and
// magnitude, the squaring multipliers, and the final sum and compare.
// busy is high during reset and while a registered copy of rst is still high,
// and low otherwise.
// Reset empties the pipeline; requests in flight give no result.
// The receiver cannot stall: results are not held, so done and hit must be
// sampled in the cycle they appear. hit reads 0 whenever done is low.
// Circle-circle and circle-rectangle hits include exact contact; rectangle-
// rectangle needs strict overlap; any other pairing reports no hit.
module shape_overlap_test_top
  import sot_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [TYPE_W-1:0]          first_type,
  input  logic signed [COORD_W-1:0]  first_x,
  input  logic signed [COORD_W-1:0]  first_y,
  input  logic [LEN_W-1:0]           first_width,
  input  logic [LEN_W-1:0]           first_height,
  input  logic [LEN_W-1:0]           first_radius,
  input  logic [TYPE_W-1:0]          second_type,
  input  logic signed [COORD_W-1:0]  second_x,
  input  logic signed [COORD_W-1:0]  second_y,
  input  logic [LEN_W-1:0]           second_width,
  input  logic [LEN_W-1:0]           second_height,
  input  logic [LEN_W-1:0]           second_radius,
  output logic                       done,
  output logic                       hit
);

  localparam int DW = COORD_W + 2;   // clamp differences
  localparam int MW = DW - 1;        // magnitudes
  localparam int SW = 2 * MW;        // squared magnitudes
  localparam int RW = LEN_W + 1;     // radius sum
  localparam int EW = COORD_W + 1;   // rectangle edges

  logic busy_hold;
  logic accept;

  always_ff @(posedge clk) begin
    busy_hold <= rst;
  end

  assign busy   = rst | busy_hold;
  assign accept = start & ~busy;

  // ---------------- stage 1 ----------------
  logic                  cc, rr, cr, rc;
  logic [1:0]            pair_in;
  logic signed [COORD_W-1:0] cx, cy, rx, ry;
  logic [LEN_W-1:0]      rw, rh, crad;
  logic signed [DW-1:0]  cxe, cye, rx_hi, ry_hi;
  logic signed [EW-1:0]  ax, ay, bx, by, ax_hi, ay_hi, bx_hi, by_hi;

  always_comb begin
    cc = (first_type == TYPE_CIRCLE) && (second_type == TYPE_CIRCLE);
    rr = (first_type == TYPE_RECT) && (second_type == TYPE_RECT);
    cr = (first_type == TYPE_CIRCLE) && (second_type == TYPE_RECT);
    rc = (first_type == TYPE_RECT) && (second_type == TYPE_CIRCLE);
    if (cc) begin
      pair_in = PAIR_CC;
    end else if (rr) begin
      pair_in = PAIR_RR;
    end else if (cr || rc) begin
      pair_in = PAIR_CR;
    end else begin
      pair_in = PAIR_NONE;
    end
    cx    = cr ? first_x : second_x;
    cy    = cr ? first_y : second_y;
    crad  = cr ? first_radius : second_radius;
    rx    = cr ? second_x : first_x;
    ry    = cr ? second_y : first_y;
    rw    = cr ? second_width : first_width;
    rh    = cr ? second_height : first_height;
    cxe   = {{2{cx[COORD_W-1]}}, cx};
    cye   = {{2{cy[COORD_W-1]}}, cy};
    rx_hi = {{2{rx[COORD_W-1]}}, rx} + {3'b000, rw};
    ry_hi = {{2{ry[COORD_W-1]}}, ry} + {3'b000, rh};
    ax    = {first_x[COORD_W-1], first_x};
    ay    = {first_y[COORD_W-1], first_y};
    bx    = {second_x[COORD_W-1], second_x};
    by    = {second_y[COORD_W-1], second_y};
    ax_hi = ax + {2'b00, first_width};
    ay_hi = ay + {2'b00, first_height};
    bx_hi = bx + {2'b00, second_width};
    by_hi = by + {2'b00, second_height};
  end

  logic                 v1;
  logic [1:0]           pair1;
  logic                 rr_hit1;
  logic signed [DW-1:0] dx_cc1, dy_cc1, ex_lo1, ex_hi1, ey_lo1, ey_hi1;
  logic [RW-1:0]        rsum1;
  logic [LEN_W-1:0]     crad1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    pair1   <= pair_in;
    rr_hit1 <= (ax < bx_hi) && (ax_hi > bx) && (ay < by_hi) && (ay_hi > by);
    dx_cc1  <= {{2{first_x[COORD_W-1]}}, first_x} - {{2{second_x[COORD_W-1]}}, second_x};
    dy_cc1  <= {{2{first_y[COORD_W-1]}}, first_y} - {{2{second_y[COORD_W-1]}}, second_y};
    ex_lo1  <= cxe - {{2{rx[COORD_W-1]}}, rx};
    ex_hi1  <= cxe - rx_hi;
    ey_lo1  <= cye - {{2{ry[COORD_W-1]}}, ry};
    ey_hi1  <= cye - ry_hi;
    rsum1   <= {1'b0, first_radius} + {1'b0, second_radius};
    crad1   <= crad;
  end

  // ---------------- stage 2 ----------------
  logic signed [DW-1:0] dx_sel, dy_sel, dx_neg, dy_neg, dx_abs, dy_abs;
  logic [RW-1:0]        r_sel;

  always_comb begin
    if (pair1 == PAIR_CC) begin
      dx_sel = dx_cc1;
      dy_sel = dy_cc1;
      r_sel  = rsum1;
    end else begin
      if (ex_lo1[DW-1]) begin
        dx_sel = ex_lo1;
      end else if (!ex_hi1[DW-1] && (ex_hi1 != '0)) begin
        dx_sel = ex_hi1;
      end else begin
        dx_sel = '0;
      end
      if (ey_lo1[DW-1]) begin
        dy_sel = ey_lo1;
      end else if (!ey_hi1[DW-1] && (ey_hi1 != '0)) begin
        dy_sel = ey_hi1;
      end else begin
        dy_sel = '0;
      end
      r_sel = {1'b0, crad1};
    end
    dx_neg = -dx_sel;
    dy_neg = -dy_sel;
    dx_abs = dx_sel[DW-1] ? dx_neg : dx_sel;
    dy_abs = dy_sel[DW-1] ? dy_neg : dy_sel;
  end

  logic          v2;
  logic [1:0]    pair2;
  logic          rr_hit2;
  logic [MW-1:0] mx2, my2;
  logic [RW-1:0] r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    pair2   <= pair1;
    rr_hit2 <= rr_hit1;
    mx2     <= dx_abs[MW-1:0];
    my2     <= dy_abs[MW-1:0];
    r2      <= r_sel;
  end

  // ---------------- stage 3 ----------------
  logic            v3;
  logic [1:0]      pair3;
  logic            rr_hit3;
  logic [SW-1:0]   sqx3, sqy3;
  logic [2*RW-1:0] sqr3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    pair3   <= pair2;
    rr_hit3 <= rr_hit2;
    sqx3    <= SW'(mx2) * SW'(mx2);
    sqy3    <= SW'(my2) * SW'(my2);
    sqr3    <= (2*RW)'(r2) * (2*RW)'(r2);
  end

  // ---------------- stage 4 ----------------
  logic [SW:0] dist_sq;
  logic        hit_next;

  always_comb begin
    dist_sq = {1'b0, sqx3} + {1'b0, sqy3};
    case (pair3) inside
      PAIR_RR: hit_next = rr_hit3;
      PAIR_CC, PAIR_CR: hit_next = (dist_sq <= (SW+1)'(sqr3));
      default: hit_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= v3;
      hit  <= v3 & hit_next;
    end
  end

endmodule

// ----- hdl/sot_checker.sv -----
// Port-level checker for the shape overlap test block, with its bind.
`include "shape_overlap_test_top_defines.svh"

module sot_checker
  import sot_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [TYPE_W-1:0] first_type,
  input logic [TYPE_W-1:0] second_type,
  input logic              done,
  input logic              hit
);

  logic req;
  logic odd_pair;

  assign req      = start & ~busy;
  assign odd_pair = first_type[1] | second_type[1];

  `SOT_ASSERT_IMPL(a_result_follows, req, ##LATENCY done, "request gave no result")
  `SOT_ASSERT_IMPL(a_no_phantom, done, $past(req, LATENCY), "result without request")
  `SOT_ASSERT_IMPL(a_other_type_miss, req && odd_pair, ##LATENCY !hit, "other type hit")
  `SOT_ASSERT_NEXT(a_hit_only_on_done, !done ##1 1'b1, done || !hit, "hit without done")

endmodule

bind shape_overlap_test_top sot_checker u_sot_checker (.*);

// ----- verif/tb_shape_overlap_test_top.sv -----
// Self-checking testbench for the shape overlap test block.
module tb_shape_overlap_test_top;
  import sot_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_PAIRS = 1950;
  localparam int CALM_TAIL = 300;
  localparam logic [TYPE_W-1:0] TYPE_OTHER = 2'd2;
  localparam logic [TYPE_W-1:0] TYPE_SPARE = 2'd3;

  typedef struct {
    logic [TYPE_W-1:0]         kind;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [LEN_W-1:0]          w;
    logic [LEN_W-1:0]          h;
    logic [LEN_W-1:0]          r;
  } shape_t;

  class hit_ledger;
    bit expected_hits[$];
    int mismatches = 0;

    task report(string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatches++;
    endtask

    function void note_request(bit predicted);
      expected_hits.push_back(predicted);
    endfunction

    function int outstanding();
      return expected_hits.size();
    endfunction

    task check_result(logic got);
      bit want;
      if (expected_hits.size() == 0) begin
        report($sformatf("result hit=%b with no request outstanding", got));
      end else begin
        want = expected_hits.pop_front();
        if (got !== want)
          report($sformatf("hit expected %b, got %b", want, got));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [TYPE_W-1:0] first_type = '0;
  logic signed [COORD_W-1:0] first_x = '0;
  logic signed [COORD_W-1:0] first_y = '0;
  logic [LEN_W-1:0] first_width = '0;
  logic [LEN_W-1:0] first_height = '0;
  logic [LEN_W-1:0] first_radius = '0;
  logic [TYPE_W-1:0] second_type = '0;
  logic signed [COORD_W-1:0] second_x = '0;
  logic signed [COORD_W-1:0] second_y = '0;
  logic [LEN_W-1:0] second_width = '0;
  logic [LEN_W-1:0] second_height = '0;
  logic [LEN_W-1:0] second_radius = '0;
  logic done;
  logic hit;

  hit_ledger book = new();

  shape_overlap_test_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .first_type(first_type),
    .first_x(first_x),
    .first_y(first_y),
    .first_width(first_width),
    .first_height(first_height),
    .first_radius(first_radius),
    .second_type(second_type),
    .second_x(second_x),
    .second_y(second_y),
    .second_width(second_width),
    .second_height(second_height),
    .second_radius(second_radius),
    .done(done),
    .hit(hit)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Closed rectangle, so contact at the clamped point counts.
  function automatic bit circle_meets_rect(shape_t c, shape_t b);
    longint cx, cy, left, bottom, wd, ht, rad, nx, ny, dx, dy;
    cx = c.x;
    cy = c.y;
    left = b.x;
    bottom = b.y;
    wd = b.w;
    ht = b.h;
    rad = c.r;
    nx = (cx < left) ? left : (cx > left + wd) ? left + wd : cx;
    ny = (cy < bottom) ? bottom : (cy > bottom + ht) ? bottom + ht : cy;
    dx = cx - nx;
    dy = cy - ny;
    return dx * dx + dy * dy <= rad * rad;
  endfunction

  function automatic bit shapes_overlap(shape_t a, shape_t b);
    longint ax, ay, aw, ah, ar, bx, by, bw, bh, br;
    ax = a.x; ay = a.y; aw = a.w; ah = a.h; ar = a.r;
    bx = b.x; by = b.y; bw = b.w; bh = b.h; br = b.r;
    if (a.kind == TYPE_CIRCLE && b.kind == TYPE_CIRCLE)
      return (ax - bx) * (ax - bx) + (ay - by) * (ay - by) <= (ar + br) * (ar + br);
    if (a.kind == TYPE_RECT && b.kind == TYPE_RECT)
      return ax < bx + bw && ax + aw > bx && ay < by + bh && ay + ah > by;
    if (a.kind == TYPE_CIRCLE && b.kind == TYPE_RECT)
      return circle_meets_rect(a, b);
    if (a.kind == TYPE_RECT && b.kind == TYPE_CIRCLE)
      return circle_meets_rect(b, a);
    return 1'b0;
  endfunction

  function automatic shape_t rect_at(int x, int y, int w, int h);
    shape_t s;
    s.kind = TYPE_RECT;
    s.x = COORD_W'(x);
    s.y = COORD_W'(y);
    s.w = LEN_W'(w);
    s.h = LEN_W'(h);
    s.r = LEN_W'($urandom);
    return s;
  endfunction

  function automatic shape_t circle_at(int x, int y, int r);
    shape_t s;
    s.kind = TYPE_CIRCLE;
    s.x = COORD_W'(x);
    s.y = COORD_W'(y);
    s.w = LEN_W'($urandom);
    s.h = LEN_W'($urandom);
    s.r = LEN_W'(r);
    return s;
  endfunction

  function automatic shape_t odd_at(logic [TYPE_W-1:0] kind, int x, int y);
    shape_t s;
    s = rect_at(x, y, 32767, 32767);
    s.kind = kind;
    s.r = '1;
    return s;
  endfunction

  // Shapes cluster around a common point so contact and near misses are common.
  function automatic shape_t random_shape(logic signed [COORD_W-1:0] cx,
                                          logic signed [COORD_W-1:0] cy);
    shape_t s;
    int pick;
    pick = $urandom_range(0, 19);
    s.kind = (pick < 9) ? TYPE_RECT : (pick < 18) ? TYPE_CIRCLE :
             (pick == 18) ? TYPE_OTHER : TYPE_SPARE;
    if ($urandom_range(0, 4) == 0) begin
      s.x = COORD_W'($urandom);
      s.y = COORD_W'($urandom);
      s.w = LEN_W'($urandom);
      s.h = LEN_W'($urandom);
      s.r = LEN_W'($urandom);
    end else begin
      s.x = cx + COORD_W'($urandom_range(0, 128)) - COORD_W'(64);
      s.y = cy + COORD_W'($urandom_range(0, 128)) - COORD_W'(64);
      s.w = ($urandom_range(0, 7) == 0) ? '0 : LEN_W'($urandom_range(0, 96));
      s.h = ($urandom_range(0, 7) == 0) ? '0 : LEN_W'($urandom_range(0, 96));
      s.r = ($urandom_range(0, 7) == 0) ? '0 : LEN_W'($urandom_range(0, 96));
    end
    return s;
  endfunction

  task send_pair(shape_t a, shape_t b);
    first_type <= a.kind;
    first_x <= a.x;
    first_y <= a.y;
    first_width <= a.w;
    first_height <= a.h;
    first_radius <= a.r;
    second_type <= b.kind;
    second_x <= b.x;
    second_y <= b.y;
    second_width <= b.w;
    second_height <= b.h;
    second_radius <= b.r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    book.note_request(shapes_overlap(a, b));
  endtask

  task idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task wait_for_results();
    if (book.outstanding() != 0) begin
      start <= 1'b0;
      while (book.outstanding() != 0) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) book.check_result(hit);
  end

  initial begin
    #(CLK_PERIOD * 200000);
    $display("tb_shape_overlap_test_top: done, errors");
    $finish;
  end

  initial begin
    int idle_rate;
    int waited;
    logic signed [COORD_W-1:0] cx, cy;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // circle pairs: exact contact, near miss, extreme coordinates, zero radius
    send_pair(circle_at(0, 0, 16), circle_at(32, 0, 16));
    send_pair(circle_at(0, 0, 16), circle_at(33, 0, 16));
    send_pair(circle_at(-32768, 0, 32767), circle_at(32767, 0, 32767));
    send_pair(circle_at(-32768, 0, 32767), circle_at(32766, 0, 32767));
    send_pair(circle_at(-32768, -32768, 32767), circle_at(32767, 32767, 32767));
    send_pair(circle_at(100, -100, 0), circle_at(100, -100, 0));
    // rectangle pairs: shared edge, overlap, zero width, extremes
    send_pair(rect_at(0, 0, 16, 16), rect_at(16, 0, 16, 16));
    send_pair(rect_at(0, 0, 16, 16), rect_at(15, 15, 16, 16));
    send_pair(rect_at(0, 0, 0, 16), rect_at(-8, 0, 16, 16));
    send_pair(rect_at(-32768, -32768, 32767, 32767), rect_at(32767, 32767, 32767, 32767));
    send_pair(rect_at(-32768, -32768, 32767, 32767), rect_at(-2, -2, 32767, 32767));
    // circle against rectangle, both orders
    send_pair(circle_at(8, 8, 0), rect_at(0, 0, 16, 16));
    send_pair(circle_at(19, 20, 5), rect_at(0, 0, 16, 16));
    send_pair(circle_at(19, 20, 4), rect_at(0, 0, 16, 16));
    send_pair(rect_at(0, 0, 16, 16), circle_at(16, 8, 0));
    send_pair(rect_at(0, 0, 16, 16), circle_at(17, 8, 0));
    send_pair(circle_at(5, 0, 5), rect_at(0, 0, 0, 0));
    send_pair(circle_at(32767, 32767, 32767), rect_at(-32768, -32768, 32767, 32767));
    send_pair(rect_at(32767, 32767, 32767, 32767), circle_at(-32768, -32768, 32767));
    // unsupported kinds never hit, even when the shapes coincide
    send_pair(odd_at(TYPE_OTHER, 0, 0), circle_at(0, 0, 32767));
    send_pair(circle_at(0, 0, 32767), odd_at(TYPE_SPARE, 0, 0));
    send_pair(odd_at(TYPE_SPARE, -1, -1), rect_at(-1, -1, 32767, 32767));
    send_pair(odd_at(TYPE_OTHER, 0, 0), odd_at(TYPE_SPARE, 0, 0));
    send_pair(rect_at(0, 0, 16, 16), odd_at(TYPE_OTHER, 0, 0));
    wait_for_results();

    idle_rate = 0;
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 100 == 0) idle_rate = $urandom_range(0, 3);
      if (i == RANDOM_PAIRS / 2) wait_for_results();
      cx = COORD_W'($urandom);
      cy = COORD_W'($urandom);
      send_pair(random_shape(cx, cy), random_shape(cx, cy));
      if (i < RANDOM_PAIRS - CALM_TAIL && idle_rate != 0 &&
          $urandom_range(0, 3) < idle_rate)
        idle_cycles($urandom_range(1, 6));
    end

    start <= 1'b0;
    waited = 0;
    while (book.outstanding() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 2) @(posedge clk);
    if (book.outstanding() != 0)
      book.report($sformatf("%0d results never arrived", book.outstanding()));
    if (book.mismatches == 0) begin
      $display("tb_shape_overlap_test_top: done, clean");
    end else begin
      $display("tb_shape_overlap_test_top: done, errors");
    end
    $finish;
  end

endmodule
